// ===== src/pwms_pkg.sv =====
// Package for the 3D position window median select block.
// Holds the point type, pipeline advance controls and the abs-difference helper.
// No dependencies.
package pwms_pkg;

	localparam int DEF_HALF_WIDTH = 2;
	localparam int COORD_W = 24;
	localparam int SQ_W = 2 * COORD_W;
	localparam int DIST_W = SQ_W + 2;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	// advance strobes broadcast along the cell row
	typedef struct packed {
		logic shift;
		logic clear;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} adv_t;

	function automatic logic [COORD_W-1:0] abs_diff(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic signed [COORD_W:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		return d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
	endfunction

endpackage

// ===== src/position_window_median_select.sv =====
// 3D position window median select: top level with the cell row, pipeline
// control and result sequencer.
// Depends on pwms_pkg, pwms_cell and pwms_rank.
//
// Input channel (in_valid/in_stall) takes one tracker sample per item: pos_x,
// pos_y, pos_z and final_sample. Output channel (out_valid/out_stall) gives the
// selected position with was_filtered and run_end; run_end marks the last
// result caused by an input item. An item is taken on an edge with valid high
// and stall low.
// A window of 2*HALF_WIDTH+1 samples shifts through a row of cells. The result
// for a centre sample appears HALF_WIDTH items later; it is ranked by squared
// distance once the window is full and passed through at the track edges.
// A final item flushes every pending centre and clears the window.
// The first result of an item passes the distance, square, sum and rank stages
// and then the output register. Throughput is one item per cycle while the
// receiver does not stall; a final item holds the rank stage until all of its
// up to HALF_WIDTH+1 results are emitted, and items causing no result never do.
// Reset empties the pipeline and clears the window and sample count.
// When the receiver stalls, the output register holds and items pile up in
// the four stages; in_stall rises once they are all full.
module position_window_median_select #(
	parameter int HALF_WIDTH = pwms_pkg::DEF_HALF_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [pwms_pkg::COORD_W-1:0]  pos_x,
	input  logic signed [pwms_pkg::COORD_W-1:0]  pos_y,
	input  logic signed [pwms_pkg::COORD_W-1:0]  pos_z,
	input  logic                                 final_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pwms_pkg::COORD_W-1:0]  out_x,
	output logic signed [pwms_pkg::COORD_W-1:0]  out_y,
	output logic signed [pwms_pkg::COORD_W-1:0]  out_z,
	output logic                                 was_filtered,
	output logic                                 run_end
);

	localparam int WIN_LEN = 2 * HALF_WIDTH + 1;
	localparam int IDX_W = $clog2(WIN_LEN);
	localparam int CNT_W = $clog2(WIN_LEN);
	localparam int TOT_W = $clog2(HALF_WIDTH + 2);

	pwms_pkg::point_t in_pt;
	pwms_pkg::point_t nbr_pt [WIN_LEN];
	pwms_pkg::point_t slot_pt [WIN_LEN];
	pwms_pkg::point_t pt_s3 [WIN_LEN];
	pwms_pkg::point_t pt_s4 [WIN_LEN];
	logic [pwms_pkg::DIST_W-1:0] dist_s3 [WIN_LEN];
	logic [IDX_W-1:0] med_idx_s4;
	pwms_pkg::adv_t adv;

	logic [CNT_W-1:0] seen_q;
	logic v_s1, v_s2, v_s3, v_s4;
	logic filt_s1, filt_s2, filt_s3, filt_s4;
	logic [TOT_W-1:0] tot_s1, tot_s2, tot_s3, tot_s4;
	logic [IDX_W-1:0] base_s1, base_s2, base_s3, base_s4;
	logic [TOT_W-1:0] k_q;

	logic accept, rdy1, rdy2, rdy3, rdy4, go4;
	logic out_free, emit, emit_last;
	logic has_norm, filt_in;
	logic [TOT_W-1:0] flush_cnt, tot_in;
	logic [IDX_W-1:0] base_in, sel_idx;
	pwms_pkg::point_t sel_pt;

	logic out_valid_q;
	logic signed [pwms_pkg::COORD_W-1:0] out_x_q, out_y_q, out_z_q;
	logic was_filtered_q, run_end_q;

	always_comb begin
		in_pt.x = pos_x;
		in_pt.y = pos_y;
		in_pt.z = pos_z;
	end

	for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
		if (i == WIN_LEN - 1) begin : g_tail
			assign nbr_pt[i] = in_pt;
		end else begin : g_body
			assign nbr_pt[i] = slot_pt[i+1];
		end
		pwms_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.nbr_pt  (nbr_pt[i]),
			.ctr_pt  (nbr_pt[HALF_WIDTH]),
			.slot_pt (slot_pt[i]),
			.pt_s3   (pt_s3[i]),
			.dist_s3 (dist_s3[i])
		);
	end

	pwms_rank #(
		.HALF_WIDTH (HALF_WIDTH)
	) u_rank (
		.clk        (clk),
		.adv        (adv),
		.pt_s3      (pt_s3),
		.dist_s3    (dist_s3),
		.pt_s4      (pt_s4),
		.med_idx_s4 (med_idx_s4)
	);

	// per-item result plan, from the count before this sample
	always_comb begin
		has_norm = seen_q >= CNT_W'(HALF_WIDTH);
		filt_in = seen_q >= CNT_W'(2 * HALF_WIDTH);
		if (!final_sample) begin
			flush_cnt = '0;
		end else if (has_norm) begin
			flush_cnt = TOT_W'(HALF_WIDTH);
		end else begin
			flush_cnt = TOT_W'(seen_q) + TOT_W'(1);
		end
		tot_in = TOT_W'(has_norm) + flush_cnt;
		base_in = has_norm ? IDX_W'(HALF_WIDTH) : IDX_W'(2 * HALF_WIDTH) - IDX_W'(seen_q);
	end

	// pipeline flow, collapsing bubbles
	always_comb begin
		out_free = !out_valid_q || !out_stall;
		emit = v_s4 && (tot_s4 != '0) && out_free;
		emit_last = (k_q == tot_s4 - TOT_W'(1));
		go4 = v_s4 && ((tot_s4 == '0) || (emit && emit_last));
		rdy4 = !v_s4 || go4;
		rdy3 = !v_s3 || rdy4;
		rdy2 = !v_s2 || rdy3;
		rdy1 = !v_s1 || rdy2;
		accept = in_valid && rdy1;
		adv.shift = accept;
		adv.clear = final_sample;
		adv.en_s2 = v_s1 && rdy2;
		adv.en_s3 = v_s2 && rdy3;
		adv.en_s4 = v_s3 && rdy4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (final_sample) begin
					seen_q <= '0;
				end else if (seen_q < CNT_W'(2 * HALF_WIDTH)) begin
					seen_q <= seen_q + CNT_W'(1);
				end
			end
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (emit) begin
				k_q <= emit_last ? '0 : k_q + TOT_W'(1);
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			filt_s1 <= filt_in;
			tot_s1 <= tot_in;
			base_s1 <= base_in;
		end
		if (adv.en_s2) begin
			filt_s2 <= filt_s1;
			tot_s2 <= tot_s1;
			base_s2 <= base_s1;
		end
		if (adv.en_s3) begin
			filt_s3 <= filt_s2;
			tot_s3 <= tot_s2;
			base_s3 <= base_s2;
		end
		if (adv.en_s4) begin
			filt_s4 <= filt_s3;
			tot_s4 <= tot_s3;
			base_s4 <= base_s3;
		end
	end

	// first result of a full window is ranked; the rest walk up from base
	always_comb begin
		if (k_q == '0 && filt_s4) begin
			sel_idx = med_idx_s4;
		end else begin
			sel_idx = base_s4 + IDX_W'(k_q);
		end
		sel_pt = pt_s4[sel_idx];
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_x_q <= sel_pt.x;
			out_y_q <= sel_pt.y;
			out_z_q <= sel_pt.z;
			was_filtered_q <= (k_q == '0) && filt_s4;
			run_end_q <= emit_last;
		end
	end

	assign in_stall = !rdy1;
	assign out_valid = out_valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign out_z = out_z_q;
	assign was_filtered = was_filtered_q;
	assign run_end = run_end_q;

	a_seen_sat: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CNT_W'(2 * HALF_WIDTH))
		else $error("sample count above window span");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && tot_s4 != '0 |-> k_q < tot_s4)
		else $error("result index past item total");

	a_k_held: assert property (@(posedge clk) disable iff (!arst_n)
		k_q != '0 |-> v_s4 && tot_s4 > TOT_W'(1))
		else $error("result sequence without a multi-result item");

	a_med_idx: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && filt_s4 |-> med_idx_s4 <= IDX_W'(2 * HALF_WIDTH))
		else $error("median slot outside window");

	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_last |=> out_valid && run_end)
		else $error("last result of an item not flagged");

endmodule

// ===== src/pwms_cell.sv =====
// One window cell: holds a slot, shifts to its left neighbor, and computes
// the squared distance of its shifted sample to the window centre.
// Depends on pwms_pkg.
module pwms_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pwms_pkg::adv_t                     adv,
	input  pwms_pkg::point_t                   nbr_pt,
	input  pwms_pkg::point_t                   ctr_pt,
	output pwms_pkg::point_t                   slot_pt,
	output pwms_pkg::point_t                   pt_s3,
	output logic [pwms_pkg::DIST_W-1:0]        dist_s3
);

	pwms_pkg::point_t slot_q;
	pwms_pkg::point_t pt_s1;
	pwms_pkg::point_t pt_s2;
	pwms_pkg::point_t pt_s3_r;
	logic [pwms_pkg::COORD_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [pwms_pkg::SQ_W-1:0] sqx_s2, sqy_s2, sqz_s2;
	logic [pwms_pkg::DIST_W-1:0] dist_s3_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (adv.shift) begin
			slot_q <= adv.clear ? '0 : nbr_pt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.shift) begin
			pt_s1 <= nbr_pt;
			dx_s1 <= pwms_pkg::abs_diff(nbr_pt.x, ctr_pt.x);
			dy_s1 <= pwms_pkg::abs_diff(nbr_pt.y, ctr_pt.y);
			dz_s1 <= pwms_pkg::abs_diff(nbr_pt.z, ctr_pt.z);
		end
		if (adv.en_s2) begin
			pt_s2 <= pt_s1;
			sqx_s2 <= {{pwms_pkg::COORD_W{1'b0}}, dx_s1} * {{pwms_pkg::COORD_W{1'b0}}, dx_s1};
			sqy_s2 <= {{pwms_pkg::COORD_W{1'b0}}, dy_s1} * {{pwms_pkg::COORD_W{1'b0}}, dy_s1};
			sqz_s2 <= {{pwms_pkg::COORD_W{1'b0}}, dz_s1} * {{pwms_pkg::COORD_W{1'b0}}, dz_s1};
		end
		if (adv.en_s3) begin
			pt_s3_r <= pt_s2;
			dist_s3_r <= pwms_pkg::DIST_W'(sqx_s2) + pwms_pkg::DIST_W'(sqy_s2)
				+ pwms_pkg::DIST_W'(sqz_s2);
		end
	end

	assign slot_pt = slot_q;
	assign pt_s3 = pt_s3_r;
	assign dist_s3 = dist_s3_r;

endmodule

// ===== src/pwms_rank.sv =====
// Ranking stage: ranks all window distances (ties to the older slot) and
// registers the slot of the median rank together with the window snapshot.
// Depends on pwms_pkg.
module pwms_rank #(
	parameter int HALF_WIDTH = pwms_pkg::DEF_HALF_WIDTH,
	localparam int WIN_LEN = 2 * HALF_WIDTH + 1,
	localparam int IDX_W = $clog2(WIN_LEN)
) (
	input  logic                          clk,
	input  pwms_pkg::adv_t                adv,
	input  pwms_pkg::point_t              pt_s3 [WIN_LEN],
	input  logic [pwms_pkg::DIST_W-1:0]   dist_s3 [WIN_LEN],
	output pwms_pkg::point_t              pt_s4 [WIN_LEN],
	output logic [IDX_W-1:0]              med_idx_s4
);

	logic [IDX_W-1:0] rank [WIN_LEN];
	logic [IDX_W-1:0] med_idx;
	pwms_pkg::point_t pt_s4_r [WIN_LEN];
	logic [IDX_W-1:0] med_idx_r;

	always_comb begin
		for (int i = 0; i < WIN_LEN; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WIN_LEN; j++) begin
				if (dist_s3[j] < dist_s3[i] || (dist_s3[j] == dist_s3[i] && j < i)) begin
					rank[i] = rank[i] + IDX_W'(1);
				end
			end
		end
		// ranks form a permutation, so exactly one slot matches
		med_idx = IDX_W'(HALF_WIDTH);
		for (int i = 0; i < WIN_LEN; i++) begin
			if (rank[i] == IDX_W'(HALF_WIDTH)) begin
				med_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s4) begin
			pt_s4_r <= pt_s3;
			med_idx_r <= med_idx;
		end
	end

	assign pt_s4 = pt_s4_r;
	assign med_idx_s4 = med_idx_r;

endmodule

// ===== bench/tb_position_window_median_select.sv =====
// Self-checking bench for position_window_median_select: directed tracks from a table,
// then random tracks, checked against a window/median predictor kept in this file.
// Depends on pwms_pkg and the position_window_median_select RTL.
module tb_position_window_median_select;

	localparam int COORD_W = pwms_pkg::COORD_W;
	localparam int HW = pwms_pkg::DEF_HALF_WIDTH;
	localparam int WIN = 2 * HW + 1;
	localparam int RANDOM_ITEMS = 137;
	localparam int CALM_FROM = 115;
	localparam logic signed [COORD_W-1:0] CMAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] CMIN = 24'sh800000;

	typedef pwms_pkg::point_t point_t;

	typedef struct packed {
		point_t p;
		logic   filtered;
		logic   run_end;
	} selection_t;

	// one directed item; the w* fields hold a typed-in result where typed is set
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      fin;
		logic                      typed;
		logic signed [COORD_W-1:0] wx;
		logic signed [COORD_W-1:0] wy;
		logic signed [COORD_W-1:0] wz;
		logic                      wfilt;
		logic                      wend;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic final_sample;
	logic out_valid;
	logic out_stall;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic signed [COORD_W-1:0] out_z;
	logic was_filtered;
	logic run_end;

	point_t      track_win [WIN];
	int unsigned track_len;
	selection_t  step_sel [$];
	selection_t  pending_sel [$];
	int          fault_count;
	logic        calm;
	logic        gaps_on;

	dir_row_t dir_rows [23] = '{
		// single-sample tracks pass straight through
		'{CMAX, CMAX, CMAX, 1'b1, 1'b1, CMAX, CMAX, CMAX, 1'b0, 1'b1},
		'{CMIN, CMAX, CMIN, 1'b1, 1'b1, CMIN, CMAX, CMIN, 1'b0, 1'b1},
		// two-sample track
		'{0, 0, 0, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{1, -1, 1, 1'b1, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		// three samples: normal result plus two flushed on the final item
		'{-1, -1, -1, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{5, 6, 7, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{CMAX, CMIN, 0, 1'b1, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		// full window with extreme distances
		'{CMIN, CMIN, CMIN, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{CMAX, CMAX, CMAX, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{0, 0, 0, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{CMAX, CMIN, CMAX, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{CMIN, CMAX, CMIN, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{1, 1, 1, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{-2, 3, -4, 1'b1, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		// equal distances around the centre: the older slot ranks first
		'{10, 0, 0, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{0, 10, 0, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{0, 0, 0, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{-10, 0, 0, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{0, -10, 0, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{0, 0, 10, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{0, 0, -10, 1'b1, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		// identical points, track left open into the random part
		'{7, 7, 7, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
		'{7, 7, 7, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0}
	};

	position_window_median_select #(.HALF_WIDTH(HW)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.final_sample (final_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.was_filtered (was_filtered),
		.run_end      (run_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint sq_dist(point_t a, point_t b);
		longint dx;
		longint dy;
		longint dz;
		dx = longint'($signed(a.x)) - longint'($signed(b.x));
		dy = longint'($signed(a.y)) - longint'($signed(b.y));
		dz = longint'($signed(a.z)) - longint'($signed(b.z));
		return dx * dx + dy * dy + dz * dz;
	endfunction

	function automatic int median_slot();
		longint d [WIN];
		int rank;
		for (int i = 0; i < WIN; i++)
			d[i] = sq_dist(track_win[HW], track_win[i]);
		for (int i = 0; i < WIN; i++) begin
			rank = 0;
			for (int j = 0; j < WIN; j++)
				if (d[j] < d[i] || (d[j] == d[i] && j < i))
					rank++;
			if (rank == HW)
				return i;
		end
		return HW;
	endfunction

	function automatic void emit_slot(int slot, logic filtered);
		selection_t s;
		s.p = track_win[slot];
		s.filtered = filtered;
		s.run_end = 1'b0;
		step_sel.insert(step_sel.size(), s);
	endfunction

	// advance the predicted window by one sample; results land in step_sel
	function automatic void track_step(point_t p, logic fin);
		int unsigned n;
		int unsigned d;
		n = track_len;
		step_sel.delete();
		for (int i = 0; i < WIN - 1; i++)
			track_win[i] = track_win[i + 1];
		track_win[WIN - 1] = p;
		if (track_len < 2 * HW)
			track_len++;
		if (n >= HW)
			emit_slot((n >= 2 * HW) ? median_slot() : HW, n >= 2 * HW);
		if (fin) begin
			d = (n >= HW) ? HW : n + 1;
			while (d > 0) begin
				d--;
				emit_slot(2 * HW - d, 1'b0);
			end
			foreach (track_win[i])
				track_win[i] = '0;
			track_len = 0;
		end
		if (step_sel.size() > 0)
			step_sel[step_sel.size() - 1].run_end = 1'b1;
	endfunction

	task automatic send_sample(input point_t p, input logic fin, input logic typed,
			input selection_t want);
		int gap;
		if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= p.x;
		pos_y <= p.y;
		pos_z <= p.z;
		final_sample <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		track_step(p, fin);
		if (typed)
			pending_sel.insert(pending_sel.size(), want);
		else
			foreach (step_sel[i])
				pending_sel.insert(pending_sel.size(), step_sel[i]);
	endtask

	function automatic logic signed [COORD_W-1:0] pick_coord(int style,
			logic signed [COORD_W-1:0] base);
		logic signed [COORD_W-1:0] off;
		case (style)
			0: begin
				// clustered: small offsets around a base, many near-ties
				off = COORD_W'(int'($urandom_range(0, 16)) - 8);
				return base + off;
			end
			1: return COORD_W'($urandom);
			default: begin
				case ($urandom_range(0, 3))
					0: return CMAX;
					1: return CMIN;
					2: return '0;
					default: return COORD_W'($urandom);
				endcase
			end
		endcase
	endfunction

	task automatic check_selection();
		selection_t w;
		if (pending_sel.size() == 0) begin
			$error("unexpected result x=%0d y=%0d z=%0d filtered=%0b run_end=%0b",
				out_x, out_y, out_z, was_filtered, run_end);
			fault_count++;
			return;
		end
		w = pending_sel.pop_front();
		if (out_x !== w.p.x) begin
			$error("out_x: expected %0d, actual %0d", $signed(w.p.x), out_x);
			fault_count++;
		end
		if (out_y !== w.p.y) begin
			$error("out_y: expected %0d, actual %0d", $signed(w.p.y), out_y);
			fault_count++;
		end
		if (out_z !== w.p.z) begin
			$error("out_z: expected %0d, actual %0d", $signed(w.p.z), out_z);
			fault_count++;
		end
		if (was_filtered !== w.filtered) begin
			$error("was_filtered: expected %0b, actual %0b", w.filtered, was_filtered);
			fault_count++;
		end
		if (run_end !== w.run_end) begin
			$error("run_end: expected %0b, actual %0b", w.run_end, run_end);
			fault_count++;
		end
	endtask

	// result side: checks, random stall bursts and one long hold-off
	initial begin : result_side
		int stall_left;
		int hold_left;
		int checked;
		bit hold_done;
		out_stall = 1'b0;
		stall_left = 0;
		hold_left = 0;
		checked = 0;
		hold_done = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				check_selection();
				checked++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (checked >= 60 && !hold_done) begin
				// long enough for the pipeline to fill and push back on the input
				hold_done = 1;
				hold_left = 39;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 5);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : sample_side
		dir_row_t   r;
		point_t     pt;
		selection_t want;
		selection_t none;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		logic signed [COORD_W-1:0] bz;
		int rand_sent;
		int len;
		int style;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		final_sample = 1'b0;
		calm = 1'b0;
		gaps_on = 1'b1;
		fault_count = 0;
		track_len = 0;
		foreach (track_win[i])
			track_win[i] = '0;
		none = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			pt = '{r.x, r.y, r.z};
			want.p = '{r.wx, r.wy, r.wz};
			want.filtered = r.wfilt;
			want.run_end = r.wend;
			send_sample(pt, r.fin, r.typed, want);
		end

		rand_sent = 0;
		while (rand_sent < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 16);
			// the last track ends exactly on the item budget, with a final item
			if (len > RANDOM_ITEMS - rand_sent)
				len = RANDOM_ITEMS - rand_sent;
			style = $urandom_range(0, 9);
			style = (style < 5) ? 0 : (style < 8) ? 1 : 2;
			gaps_on = ($urandom_range(0, 2) != 0);
			bx = COORD_W'($urandom);
			by = COORD_W'($urandom);
			bz = COORD_W'($urandom);
			for (int k = 0; k < len; k++) begin
				if (rand_sent >= CALM_FROM)
					calm <= 1'b1;
				pt = '{pick_coord(style, bx), pick_coord(style, by), pick_coord(style, bz)};
				send_sample(pt, k == len - 1, 1'b0, none);
				rand_sent++;
			end
		end
		in_valid <= 1'b0;

		while (pending_sel.size() != 0)
			@(posedge clk);
		// let any stray result surface
		repeat (20) @(posedge clk);
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
